/* hdl/vsl_pkg.sv */
// Package for the 3D vector set-length block.
// Holds the stage counts and the side-band structs used by the root and
// divider pipelines; depends on nothing.
package vsl_pkg;

   localparam int unsigned LANES       = 3;
   localparam int unsigned COMP_W      = 32;
   localparam int unsigned TGT_W       = 31;
   localparam int unsigned SUM_W       = 2 * COMP_W;
   localparam int unsigned ROOT_STAGES = SUM_W / 2;
   localparam int unsigned NUM_W       = 62;
   localparam int unsigned DIV_STAGES  = COMP_W;

   // Words carried alongside the square root.
   typedef struct packed {
      logic [LANES-1:0][COMP_W-1:0] mag;
      logic [LANES-1:0]             neg;
      logic [TGT_W-1:0]             tgt;
   } root_side_type;

   // Words carried alongside the division.
   typedef struct packed {
      logic [LANES-1:0] neg;
      logic [LANES-1:0] ovf;
      logic             len_zero;
   } div_side_type;

endpackage

/* hdl/vsl_isqrt.sv */
// Pipelined floor square root of a 64-bit word, one result bit per stage.
// Depends on vsl_pkg for widths and the side-band struct.
module vsl_isqrt (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   in_valid,
   input  logic [63:0]            in_value,
   input  vsl_pkg::root_side_type in_side,
   output logic                   out_valid,
   output logic [31:0]            out_root,
   output vsl_pkg::root_side_type out_side
);
   import vsl_pkg::*;

   logic [ROOT_STAGES:0]         valid_ff;
   logic [35:0]                  rem_ff  [0:ROOT_STAGES];
   logic [31:0]                  root_ff [0:ROOT_STAGES];
   logic [SUM_W-1:0]             bits_ff [0:ROOT_STAGES];
   root_side_type                side_ff [0:ROOT_STAGES];

   assign valid_ff[0] = in_valid;
   assign rem_ff[0]   = '0;
   assign root_ff[0]  = '0;
   assign bits_ff[0]  = in_value;
   assign side_ff[0]  = in_side;

   for (genvar i = 1; i <= ROOT_STAGES; i++) begin : g_stage
      logic [35:0] rem_sh;
      logic [35:0] trial;
      logic [35:0] rem_in;
      logic [31:0] root_in;

      // Bring down the next two bits and try to set the next root bit.
      always_comb begin
         rem_sh = {rem_ff[i-1][33:0], bits_ff[i-1][SUM_W-1 -: 2]};
         trial  = {2'b00, root_ff[i-1], 2'b01};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[i-1][30:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[i-1][30:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (advance) begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[i]  <= rem_in;
            root_ff[i] <= root_in;
            bits_ff[i] <= {bits_ff[i-1][SUM_W-3:0], 2'b00};
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   assign out_valid = valid_ff[ROOT_STAGES];
   assign out_root  = root_ff[ROOT_STAGES];
   assign out_side  = side_ff[ROOT_STAGES];

endmodule

/* hdl/vsl_divide.sv */
// Pipelined restoring division of three numerators by a shared divisor,
// one quotient bit per stage. Depends on vsl_pkg.
module vsl_divide (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   advance,
   input  logic                                   in_valid,
   input  logic [vsl_pkg::LANES-1:0][31:0]        in_rem,
   input  logic [vsl_pkg::LANES-1:0][31:0]        in_low,
   input  logic [31:0]                            in_den,
   input  vsl_pkg::div_side_type                  in_side,
   output logic                                   out_valid,
   output logic [vsl_pkg::LANES-1:0][31:0]        out_quot,
   output vsl_pkg::div_side_type                  out_side
);
   import vsl_pkg::*;

   logic [DIV_STAGES:0]          valid_ff;
   logic [LANES-1:0][31:0]       rem_ff  [0:DIV_STAGES];
   logic [LANES-1:0][31:0]       low_ff  [0:DIV_STAGES];
   logic [LANES-1:0][31:0]       quot_ff [0:DIV_STAGES];
   logic [31:0]                  den_ff  [0:DIV_STAGES];
   div_side_type                 side_ff [0:DIV_STAGES];

   assign valid_ff[0] = in_valid;
   assign rem_ff[0]   = in_rem;
   assign low_ff[0]   = in_low;
   assign quot_ff[0]  = '0;
   assign den_ff[0]   = in_den;
   assign side_ff[0]  = in_side;

   for (genvar i = 1; i <= DIV_STAGES; i++) begin : g_stage
      logic [LANES-1:0][31:0] rem_in;
      logic [LANES-1:0][31:0] quot_in;
      logic [32:0]            rem_sh [LANES];

      always_comb begin
         for (int l = 0; l < LANES; l++) begin
            rem_sh[l] = {rem_ff[i-1][l], low_ff[i-1][l][31]};
            if (rem_sh[l] >= {1'b0, den_ff[i-1]}) begin
               rem_in[l]  = 32'(rem_sh[l] - {1'b0, den_ff[i-1]});
               quot_in[l] = {quot_ff[i-1][l][30:0], 1'b1};
            end else begin
               rem_in[l]  = rem_sh[l][31:0];
               quot_in[l] = {quot_ff[i-1][l][30:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (advance) begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[i]  <= rem_in;
            quot_ff[i] <= quot_in;
            for (int l = 0; l < LANES; l++) begin
               low_ff[i][l] <= {low_ff[i-1][l][30:0], 1'b0};
            end
            den_ff[i]  <= den_ff[i-1];
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   assign out_valid = valid_ff[DIV_STAGES];
   assign out_quot  = quot_ff[DIV_STAGES];
   assign out_side  = side_ff[DIV_STAGES];

endmodule

/* hdl/vector_set_length_3d.sv */
// Top level of the 3D vector set-length block.
// Instantiates vsl_isqrt and vsl_divide; depends on vsl_pkg.

// The block takes one vector word per clock and returns the
// vector rescaled to the requested length: each component times the target
// divided by the floored square root of the sum of squares (the sum wraps
// modulo 2**64 like a 64-bit unsigned add), truncated toward zero and clipped
// to the signed 32-bit range. The pipeline consists of the 32-stage square root
// and the 32-stage divider, plus six stages for magnitudes, squares, sum,
// products, overflow check and the output register. Throughput is one word
// per cycle. A stalled output holds the whole pipeline only when its last
// stage is full; bubbles ahead of it keep moving. A zero vector gives zero.
module vector_set_length_3d (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // vec_x [31:0], vec_y [63:32], vec_z [95:64], target_length [126:96], pad
   input  logic [127:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // out_x [31:0], out_y [63:32], out_z [95:64]
   output logic [95:0]  rsp_tdata,
   // saturated [0]
   output logic         rsp_tuser
);
   import vsl_pkg::*;

   logic advance;

   // Stage A: component magnitudes and signs.
   logic                         a_valid_ff;
   root_side_type                a_side_ff;
   root_side_type                a_side_in;

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         a_side_in.neg[l] = req_tdata[l*COMP_W + COMP_W - 1];
         a_side_in.mag[l] = a_side_in.neg[l] ? 32'(-req_tdata[l*COMP_W +: COMP_W])
                                             : req_tdata[l*COMP_W +: COMP_W];
      end
      a_side_in.tgt = req_tdata[LANES*COMP_W +: TGT_W];
   end

   // Stage B: squares.
   logic                         b_valid_ff;
   root_side_type                b_side_ff;
   logic [LANES-1:0][SUM_W-1:0]  b_sq_ff;

   // Stage C: sum of squares, wrapping at 64 bits.
   logic                         c_valid_ff;
   root_side_type                c_side_ff;
   logic [SUM_W-1:0]             c_sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= req_tvalid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_side_ff <= a_side_in;
         b_side_ff <= a_side_ff;
         for (int l = 0; l < LANES; l++) begin
            b_sq_ff[l] <= SUM_W'(a_side_ff.mag[l]) * SUM_W'(a_side_ff.mag[l]);
         end
         c_side_ff <= b_side_ff;
         c_sum_ff  <= b_sq_ff[0] + b_sq_ff[1] + b_sq_ff[2];
      end
   end

   // Length of the vector.
   logic          r_valid;
   logic [31:0]   r_root;
   root_side_type r_side;

   vsl_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (c_valid_ff),
      .in_value  (c_sum_ff),
      .in_side   (c_side_ff),
      .out_valid (r_valid),
      .out_root  (r_root),
      .out_side  (r_side)
   );

   // Stage D: numerators, magnitude times target.
   logic                         d_valid_ff;
   logic [LANES-1:0][NUM_W-1:0]  d_num_ff;
   logic [LANES-1:0]             d_neg_ff;
   logic [31:0]                  d_len_ff;
   logic [LANES-1:0][62:0]       d_prod;

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         d_prod[l] = 63'(r_side.mag[l]) * 63'(r_side.tgt);
      end
   end

   // Stage E: the quotient must fit 32 bits, else it clips.
   logic                         e_valid_ff;
   logic [LANES-1:0][31:0]       e_rem_ff;
   logic [LANES-1:0][31:0]       e_low_ff;
   logic [31:0]                  e_den_ff;
   div_side_type                 e_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
      end else if (advance) begin
         d_valid_ff <= r_valid;
         e_valid_ff <= d_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int l = 0; l < LANES; l++) begin
            d_num_ff[l] <= d_prod[l][NUM_W-1:0];
            e_rem_ff[l] <= {2'b00, d_num_ff[l][NUM_W-1:32]};
            e_low_ff[l] <= d_num_ff[l][31:0];
            e_side_ff.ovf[l] <= {2'b00, d_num_ff[l][NUM_W-1:32]} >= d_len_ff;
         end
         d_neg_ff           <= r_side.neg;
         d_len_ff           <= r_root;
         e_den_ff           <= d_len_ff;
         e_side_ff.neg      <= d_neg_ff;
         e_side_ff.len_zero <= d_len_ff == '0;
      end
   end

   logic                    q_valid;
   logic [LANES-1:0][31:0]  q_quot;
   div_side_type            q_side;

   vsl_divide u_divide (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (e_valid_ff),
      .in_rem    (e_rem_ff),
      .in_low    (e_low_ff),
      .in_den    (e_den_ff),
      .in_side   (e_side_ff),
      .out_valid (q_valid),
      .out_quot  (q_quot),
      .out_side  (q_side)
   );

   // Output register: sign, clip and hold until taken.
   logic                    rsp_valid_ff;
   logic [95:0]             rsp_data_ff;
   logic                    rsp_sat_ff;
   logic [95:0]             rsp_data_in;
   logic                    rsp_sat_in;
   logic                    load;

   always_comb begin
      rsp_sat_in = 1'b0;
      for (int l = 0; l < LANES; l++) begin
         if (q_side.len_zero) begin
            rsp_data_in[l*32 +: 32] = '0;
         end else if (q_side.neg[l]) begin
            if (q_side.ovf[l] || q_quot[l] > 32'h8000_0000) begin
               rsp_sat_in = 1'b1;
               rsp_data_in[l*32 +: 32] = 32'h8000_0000;
            end else begin
               rsp_data_in[l*32 +: 32] = 32'(-q_quot[l]);
            end
         end else begin
            if (q_side.ovf[l] || q_quot[l] > 32'h7FFF_FFFF) begin
               rsp_sat_in = 1'b1;
               rsp_data_in[l*32 +: 32] = 32'h7FFF_FFFF;
            end else begin
               rsp_data_in[l*32 +: 32] = q_quot[l];
            end
         end
      end
   end

   assign load    = !rsp_valid_ff || rsp_tready;
   // Shifting is safe when the last stage is empty, even if the output waits.
   assign advance = load || !q_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= q_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= rsp_data_in;
         rsp_sat_ff  <= rsp_sat_in;
      end
   end

   assign req_tready = advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_sat_ff;

endmodule

/* tb/vector_set_length_3d_test.sv */
// Self-checking testbench for the 3D vector set-length block.
// Depends only on vector_set_length_3d and its package; the expected words
// come from a predictor inside this file.
`timescale 1ns / 1ps

module vector_set_length_3d_test;

   // The closing wait is sized from the block latency and is generous.
   // The watchdog limit covers the drain pause plus the longest
   // receiver stall.
   localparam int unsigned LATENCY        = 70;
   localparam int unsigned SETTLE_CYCLES  = 2 * LATENCY;
   localparam int unsigned WATCHDOG_LIMIT = 4000;
   localparam int unsigned RANDOM_VECTORS = 1300;
   localparam int unsigned MAX_REPORTS    = 10;

   localparam logic signed [31:0] COMP_MAX  = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] COMP_MIN  = 32'sh8000_0000;
   localparam logic signed [31:0] COMP_ONE  = 32'sh0001_0000;
   localparam logic [30:0]        TGT_MAX   = 31'h7FFF_FFFF;
   localparam logic [30:0]        TGT_ONE   = 31'h0001_0000;

   // One rescaled vector as the block returns it.
   typedef struct packed {
      logic        saturated;
      logic [31:0] z;
      logic [31:0] y;
      logic [31:0] x;
   } scaled_vector_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   // vec_x [31:0], vec_y [63:32], vec_z [95:64], target_length [126:96], pad
   logic [127:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   // out_x [31:0], out_y [63:32], out_z [95:64]
   logic [95:0]  rsp_tdata;
   // saturated [0]
   logic         rsp_tuser;

   scaled_vector_type pending_vectors[$];
   int unsigned       mismatch_count;
   int unsigned       idle_cycles;
   int unsigned       burst_left;

   vector_set_length_3d i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Floored square root of a 64-bit value, digit by digit in base four.
   function automatic logic [63:0] floor_root64(input logic [63:0] value);
      logic [63:0] rest;
      logic [63:0] root;
      logic [63:0] probe;
      rest  = value;
      root  = '0;
      probe = 64'h4000_0000_0000_0000;
      while (probe > rest) probe = probe >> 2;
      while (probe != 0) begin
         if (rest >= root + probe) begin
            rest = rest - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe = probe >> 2;
      end
      return root;
   endfunction

   function automatic logic [63:0] magnitude_of(input logic [31:0] comp);
      return comp[31] ? (64'h1_0000_0000 - {32'b0, comp}) : {32'b0, comp};
   endfunction

   // Scales one component by target / length, truncating towards zero and
   // clipping to the signed 32-bit range.
   function automatic logic [31:0] rescale_component(input logic [31:0] comp,
                                                     input logic [30:0] tgt,
                                                     input logic [63:0] len,
                                                     inout logic sat);
      logic [63:0] quot;
      if (len == 0) return '0;
      quot = (magnitude_of(comp) * {33'b0, tgt}) / len;
      if (comp[31]) begin
         if (quot > 64'h8000_0000) begin
            sat  = 1'b1;
            quot = 64'h8000_0000;
         end
         return 32'(64'h1_0000_0000 - quot);
      end
      if (quot > 64'h7FFF_FFFF) begin
         sat  = 1'b1;
         quot = 64'h7FFF_FFFF;
      end
      return quot[31:0];
   endfunction

   function automatic scaled_vector_type rescaled_vector(input logic [31:0] vx,
                                                         input logic [31:0] vy,
                                                         input logic [31:0] vz,
                                                         input logic [30:0] tgt);
      scaled_vector_type res;
      logic [63:0]       len;
      logic              sat;
      sat = 1'b0;
      len = floor_root64(magnitude_of(vx) * magnitude_of(vx)
                         + magnitude_of(vy) * magnitude_of(vy)
                         + magnitude_of(vz) * magnitude_of(vz));
      res.x = rescale_component(vx, tgt, len, sat);
      res.y = rescale_component(vy, tgt, len, sat);
      res.z = rescale_component(vz, tgt, len, sat);
      res.saturated = sat;
      return res;
   endfunction

   // Sends one vector word. The sender works in bursts of random length;
   // between bursts it may drop valid for a random gap. Valid is never
   // lowered and raised in the same step.
   task automatic send_vector(input logic [31:0] vx, input logic [31:0] vy,
                              input logic [31:0] vz, input logic [30:0] tgt);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      pending_vectors.push_back(rescaled_vector(vx, vy, vz, tgt));
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, tgt, vz, vy, vx};
      do @(posedge clock); while (!req_tready);
      burst_left--;
   endtask

   // Holds off the sender until every expected word has come back.
   task automatic drain_pipeline();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (pending_vectors.size() != 0) @(posedge clock);
   endtask

   // Extremes of every field, the zero vector, a zero target and
   // single-axis vectors of both signs.
   task automatic test_directed();
      send_vector('0, '0, '0, TGT_MAX);
      send_vector('0, '0, '0, '0);
      send_vector(COMP_ONE, '0, '0, TGT_ONE);
      send_vector(COMP_MAX, COMP_MAX, COMP_MAX, TGT_MAX);
      send_vector(COMP_MIN, COMP_MIN, COMP_MIN, TGT_MAX);
      send_vector(COMP_MIN, '0, '0, TGT_MAX);
      send_vector('0, COMP_MIN, '0, TGT_MAX);
      send_vector('0, '0, COMP_MIN, TGT_MAX);
      send_vector(COMP_MAX, '0, '0, TGT_MAX);
      send_vector(COMP_MAX, COMP_MIN, 32'sd1, TGT_ONE);
      send_vector(COMP_MAX, COMP_MAX, COMP_MAX, '0);
      send_vector(32'sd1, '0, '0, TGT_MAX);
      send_vector(-32'sd1, '0, '0, TGT_MAX);
      send_vector(32'sd1, -32'sd1, 32'sd1, 31'd1);
      send_vector(32'sd3, 32'sd4, '0, TGT_ONE);
      send_vector(-32'sd3, '0, 32'sd4, TGT_MAX);
      send_vector(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h5555_5555);
      send_vector(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F, 31'h2AAA_AAAA);
      send_vector(COMP_ONE, COMP_ONE, COMP_ONE, 31'd1);
   endtask

   // Components are full-range half of the time, else small (so that the
   // length can be tiny and the quotients large), zero or an extreme.
   task automatic test_random(input int unsigned count);
      logic [31:0] comp[3];
      logic [30:0] tgt;
      for (int unsigned n = 0; n < count; n++) begin
         for (int k = 0; k < 3; k++) begin
            case ($urandom_range(0, 5))
               0:       comp[k] = 32'($signed($urandom_range(0, 64)) - 32);
               1:       comp[k] = '0;
               2:       comp[k] = $urandom_range(0, 1) ? COMP_MIN : COMP_MAX;
               default: comp[k] = $urandom;
            endcase
         end
         case ($urandom_range(0, 7))
            0:       tgt = '0;
            1:       tgt = TGT_MAX;
            2:       tgt = 31'($urandom_range(0, 255));
            default: tgt = 31'($urandom);
         endcase
         send_vector(comp[0], comp[1], comp[2], tgt);
         if (n == count / 2) drain_pipeline();
      end
   endtask

   // Receiver: alternates stretches of full readiness, random stalls and
   // long regular stalls, so that gaps fall on every pipeline phase.
   initial begin
      int unsigned mode_left;
      int unsigned mode;
      int unsigned tick;
      rsp_tready = 1'b0;
      mode_left  = 0;
      mode       = 0;
      tick       = 0;
      forever begin
         @(posedge clock);
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 2);
            mode_left = $urandom_range(20, 300);
         end
         mode_left--;
         tick++;
         case (mode)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= ($urandom_range(0, 2) != 0);
            default: rsp_tready <= (tick % 23) < 5;
         endcase
      end
   end

   // Result checker: every word accepted is compared with the oldest
   // expectation, field by field.
   always @(posedge clock) begin
      scaled_vector_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_vectors.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected result word %h / %b", rsp_tdata, rsp_tuser);
         end else begin
            want = pending_vectors.pop_front();
            if (rsp_tdata[31:0] !== want.x || rsp_tdata[63:32] !== want.y
                || rsp_tdata[95:64] !== want.z || rsp_tuser !== want.saturated) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("mismatch: expected x=%h y=%h z=%h sat=%b, got x=%h y=%h z=%h sat=%b",
                           want.x, want.y, want.z, want.saturated,
                           rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[95:64], rsp_tuser);
            end
         end
      end
   end

   // Watchdog: cycles with no word moved on either side.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      mismatch_count = 0;
      idle_cycles    = 0;
      burst_left     = 0;
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      drain_pipeline();
      test_random(RANDOM_VECTORS);
      drain_pipeline();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_vectors.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
